FILE: rtl/core/md5de_pkg.sv
package md5de_pkg;

	localparam int unsigned WordW      = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds     = 64;
	localparam int unsigned QueueDepth = 4;

	localparam logic [WordW-1:0] Iv0 = 32'h67452301;
	localparam logic [WordW-1:0] Iv1 = 32'hefcdab89;
	localparam logic [WordW-1:0] Iv2 = 32'h98badcfe;
	localparam logic [WordW-1:0] Iv3 = 32'h10325476;

	localparam logic [WordW-1:0] PadByte  = 32'h00000080;
	localparam logic [3:0]       LenLoPos = 4'd14;

	// one block word handed from the front to the back
	typedef struct packed {
		logic [WordW-1:0] word;
		logic             fin;   // length high word: closes the message
	} md5de_ent_t;

	function automatic logic [WordW-1:0] md5de_k(input logic [5:0] r);
		logic [WordW-1:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5de_rot(input logic [5:0] r);
		logic [4:0] s;
		unique case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index per round
	function automatic logic [3:0] md5de_g(input logic [5:0] r);
		logic [3:0] g;
		unique case (r[5:4])
			2'd0:    g = r[3:0];
			2'd1:    g = 4'(5 * r[3:0] + 1);
			2'd2:    g = 4'(3 * r[3:0] + 5);
			2'd3:    g = 4'(7 * r[3:0]);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

FILE: rtl/core/md5de_front.sv
module md5de_front
	import md5de_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WordW-1:0] in_data,
	input  logic [2:0]       in_nbytes,
	input  logic             in_last,
	output logic             q_valid,
	input  logic             q_ready,
	output md5de_ent_t       q_ent
);

	typedef enum logic [1:0] {
		ST_DATA = 2'b01,
		ST_PAD  = 2'b10
	} fr_state_t;

	fr_state_t   state_q;
	logic [3:0]  pos_q;
	logic [63:0] count_q;
	logic        pad_first_q;
	logic        len_phase_q;
	logic [2:0]  nsat;
	logic [WordW-1:0] tail_word;
	logic        acc;
	logic        push;

	assign nsat = (in_nbytes > 3'd4) ? 3'd4 : in_nbytes;

	// partial last word with the 0x80 marker right after the valid bytes
	always_comb begin
		case (nsat)
			3'd0:    tail_word = PadByte;
			3'd1:    tail_word = {16'h0000, 8'h80, in_data[7:0]};
			3'd2:    tail_word = {8'h00, 8'h80, in_data[15:0]};
			3'd3:    tail_word = {8'h80, in_data[23:0]};
			default: tail_word = in_data;
		endcase
	end

	assign in_ready = (state_q == ST_DATA) && q_ready;
	assign acc      = in_valid && in_ready;
	assign push     = q_valid && q_ready;

	always_comb begin
		q_valid   = 1'b0;
		q_ent.word = '0;
		q_ent.fin  = 1'b0;
		unique case (state_q)
			ST_DATA: begin
				q_valid    = in_valid;
				q_ent.word = in_last ? tail_word : in_data;
			end
			ST_PAD: begin
				q_valid = 1'b1;
				q_ent.fin = len_phase_q;
				if (pad_first_q) begin
					q_ent.word = PadByte;
				end else if (len_phase_q) begin
					q_ent.word = count_q[63:32];
				end else if (pos_q == LenLoPos) begin
					q_ent.word = count_q[31:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_DATA;
			pos_q       <= '0;
			count_q     <= '0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_DATA: begin
					if (acc) begin
						pos_q <= pos_q + 4'd1;
						if (in_last) begin
							count_q     <= count_q + {58'd0, nsat, 3'b000};
							state_q     <= ST_PAD;
							pad_first_q <= (nsat == 3'd4);
							len_phase_q <= 1'b0;
						end else begin
							count_q <= count_q + 64'd32;
						end
					end
				end
				ST_PAD: begin
					if (push) begin
						// the length high word sits in word 15, so this wraps to 0
						pos_q       <= pos_q + 4'd1;
						pad_first_q <= 1'b0;
						if (len_phase_q) begin
							state_q     <= ST_DATA;
							count_q     <= '0;
							len_phase_q <= 1'b0;
						end else if (!pad_first_q && pos_q == LenLoPos) begin
							len_phase_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_DATA;
			endcase
		end
	end

endmodule

FILE: rtl/core/md5de_queue.sv
module md5de_queue
	import md5de_pkg::*;
#(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  md5de_ent_t push_ent,
	output logic       pop_valid,
	input  logic       pop_ready,
	output md5de_ent_t pop_ent
);

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	md5de_ent_t          ent_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != CntW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_ent    = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/md5de_back.sv
module md5de_back
	import md5de_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             w_valid,
	output logic             w_ready,
	input  md5de_ent_t       w_ent,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WordW-1:0] out_word,
	output logic             out_last
);

	// two block banks: one fills while the other is compressed
	logic [WordW-1:0] blk_q [2*BlockWords];
	logic             wr_bank_q;
	logic [3:0]       wr_pos_q;
	logic [1:0]       full_q;
	logic [1:0]       final_q;
	logic             rd_bank_q;

	logic             busy_q;
	logic [5:0]       round_q;
	logic [WordW-1:0] a_q, b_q, c_q, d_q;
	logic [WordW-1:0] ch_q [4];
	logic [WordW-1:0] dig_q [4];
	logic             out_busy_q;
	logic [1:0]       out_idx_q;

	logic             w_acc;
	logic             start;
	logic [WordW-1:0] f, m, t, b_nxt;
	logic [63:0]      rot_tmp;

	assign w_ready = !full_q[wr_bank_q];
	assign w_acc   = w_valid && w_ready;
	assign start   = !busy_q && full_q[rd_bank_q] && !out_busy_q;

	always_comb begin
		case (round_q[5:4])
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		m       = blk_q[{rd_bank_q, md5de_g(round_q)}];
		t       = a_q + f + md5de_k(round_q) + m;
		rot_tmp = {t, t} << md5de_rot(round_q);
		b_nxt   = b_q + rot_tmp[63:32];
	end

	assign out_valid = out_busy_q;
	assign out_word  = dig_q[out_idx_q];
	assign out_last  = (out_idx_q == 2'd3);

	always_ff @(posedge clk) begin
		if (w_acc) begin
			blk_q[{wr_bank_q, wr_pos_q}] <= w_ent.word;
		end
		if (start) begin
			a_q <= ch_q[0];
			b_q <= ch_q[1];
			c_q <= ch_q[2];
			d_q <= ch_q[3];
		end else if (busy_q) begin
			a_q <= d_q;
			b_q <= b_nxt;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (busy_q && round_q == 6'(Rounds - 1) && final_q[rd_bank_q]) begin
			dig_q[0] <= ch_q[0] + d_q;
			dig_q[1] <= ch_q[1] + b_nxt;
			dig_q[2] <= ch_q[2] + b_q;
			dig_q[3] <= ch_q[3] + c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q  <= 1'b0;
			wr_pos_q   <= '0;
			full_q     <= '0;
			final_q    <= '0;
			rd_bank_q  <= 1'b0;
			busy_q     <= 1'b0;
			round_q    <= '0;
			ch_q[0]    <= Iv0;
			ch_q[1]    <= Iv1;
			ch_q[2]    <= Iv2;
			ch_q[3]    <= Iv3;
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			if (w_acc) begin
				wr_pos_q <= wr_pos_q + 4'd1;
				if (wr_pos_q == 4'(BlockWords - 1)) begin
					full_q[wr_bank_q]  <= 1'b1;
					final_q[wr_bank_q] <= w_ent.fin;
					wr_bank_q          <= !wr_bank_q;
				end
			end
			if (start) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'(Rounds - 1)) begin
					busy_q            <= 1'b0;
					full_q[rd_bank_q] <= 1'b0;
					rd_bank_q         <= !rd_bank_q;
					if (final_q[rd_bank_q]) begin
						ch_q[0]    <= Iv0;
						ch_q[1]    <= Iv1;
						ch_q[2]    <= Iv2;
						ch_q[3]    <= Iv3;
						out_busy_q <= 1'b1;
						out_idx_q  <= '0;
					end else begin
						ch_q[0] <= ch_q[0] + d_q;
						ch_q[1] <= ch_q[1] + b_nxt;
						ch_q[2] <= ch_q[2] + b_q;
						ch_q[3] <= ch_q[3] + c_q;
					end
				end
			end
			if (out_busy_q && out_ready) begin
				out_idx_q <= out_idx_q + 2'd1;
				if (out_idx_q == 2'd3) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/core/md5_digest_engine.sv
// MD5 engine: sustained throughput is set by the round loop, which takes each 16-word
// block through a start step and then 64 rounds; the next block can fill meanwhile.
// With the back idle, the final length word passes through the queue into the block
// store, which starts the rounds; the digest is registered after the last round.
// Reset (arst_n low, async): chaining words to the MD5 IV, counters and queue
// empty; block storage is not cleared.
module md5_digest_engine
	import md5de_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream: one message word per request
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] data, [34:32] nbytes, [39:35] zero
	input  logic        s_axis_tlast,  // last
	// digest stream: A, B, C, D
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic        m_axis_tlast   // last_word
);

	// front -> queue -> back
	logic       fq_valid, fq_ready;
	md5de_ent_t fq_ent;
	logic       qb_valid, qb_ready;
	md5de_ent_t qb_ent;

	// Front: classifies each request as data or final, and generates the 0x80
	// marker, zero fill and 64-bit length words at one word per cycle while the queue has room.
	md5de_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[31:0]),
		.in_nbytes (s_axis_tdata[34:32]),
		.in_last   (s_axis_tlast),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_ent     (fq_ent)
	);

	// Short queue so the padding sequencer and compression stall independently.
	md5de_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_ent   (fq_ent),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_ent    (qb_ent)
	);

	// Back: double-buffered block store, round unit, chaining words and the
	// digest output register (held until each word is taken).
	md5de_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.w_valid   (qb_valid),
		.w_ready   (qb_ready),
		.w_ent     (qb_ent),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
